// ----- sv/assert_macros.svh -----
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, held off during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- sv/mocd_pkg.sv -----
`default_nettype none

package mocd_pkg;

  localparam int CHANNELS_DEF   = 10;
  localparam int MAX_DIVIDE_DEF = 32;

  localparam int ACTION_W  = 2;
  localparam int CHAN_W    = 4;
  localparam int DIV_W     = 6;
  localparam int DUTY_W    = 2;
  localparam int LEVEL_W   = 10;
  localparam int STATUS_W  = 2;
  localparam int COUNT_W   = 4;   // stored high/low count minus one
  localparam int PHASE_W   = 5;
  localparam int PRESC_W   = 4;
  localparam int SEL_W     = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 4;

  localparam logic [SEL_W-1:0]  PRESC_SEL_RST = 2'd3;
  localparam logic [CHAN_W-1:0] TOP_CHAN_RST  = 4'd9;
  localparam logic [COUNT_W-1:0] COUNT_RST    = 4'd1;

  // Long-divider threshold for the minimum-phase rule.
  localparam logic [DIV_W-1:0] MIN_PART_THRESH = 6'd18;
  localparam logic [DIV_W-1:0] MIN_PART_OFFSET = 6'd16;

  typedef enum logic [ACTION_W-1:0] {
    ACT_TICK   = 2'd0,
    ACT_CONFIG = 2'd1,
    ACT_READ   = 2'd2,
    ACT_SYNC   = 2'd3
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_BAD_CHAN = 2'd1,
    ST_BAD_DIV  = 2'd2,
    ST_BAD_DUTY = 2'd3
  } status_t;

  typedef enum logic [DUTY_W-1:0] {
    DUTY_HALF     = 2'd0,
    DUTY_MIN_HIGH = 2'd1,
    DUTY_MIN_LOW  = 2'd2,
    DUTY_BAD      = 2'd3
  } duty_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PRESC_SEL = 2'd0,
    REG_TOP_CHAN  = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic [LEVEL_W-1:0]  clock_levels;
    logic [STATUS_W-1:0] status;
    logic [DIV_W-1:0]    readback_divider;
    logic [DUTY_W-1:0]   readback_duty;
  } rsp_t;

  // Short phase of the asymmetric duty modes.
  function automatic logic [DIV_W-1:0] min_part(input logic [DIV_W-1:0] d);
    min_part = (d < MIN_PART_THRESH) ? DIV_W'(1) : d - MIN_PART_OFFSET;
  endfunction

endpackage

`default_nettype wire

// ----- sv/mocd_ifs.sv -----
`default_nettype none

interface mocd_cmd_if;
  logic                             valid;
  logic                             ready;
  logic [mocd_pkg::ACTION_W-1:0]    action;
  logic [mocd_pkg::CHAN_W-1:0]      channel;
  logic [mocd_pkg::DIV_W-1:0]       divider;
  logic [mocd_pkg::DUTY_W-1:0]      duty_sel;
  modport source (output valid, action, channel, divider, duty_sel, input ready);
  modport sink   (input valid, action, channel, divider, duty_sel, output ready);
endinterface

interface mocd_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [mocd_pkg::LEVEL_W-1:0]     clock_levels;
  logic [mocd_pkg::STATUS_W-1:0]    status;
  logic [mocd_pkg::DIV_W-1:0]       readback_divider;
  logic [mocd_pkg::DUTY_W-1:0]      readback_duty;
  modport source (output valid, clock_levels, status, readback_divider,
                  readback_duty, input ready);
  modport sink   (input valid, clock_levels, status, readback_divider,
                  readback_duty, output ready);
endinterface

interface mocd_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [mocd_pkg::CFG_IDX_W-1:0]   index;
  logic [mocd_pkg::CFG_DAT_W-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- sv/multi_output_clock_divider.sv -----
// Channel  Role    Payload
// cmd      sink    action, channel, divider, duty_sel
// rsp      source  clock_levels, status, readback_divider, readback_duty
// cfg      sink    index, data (0: prescale select, 1: highest channel)
//
// One command per cycle; its response is registered in the output or skid register.
// The divider state updates in the same cycle the command transfers.
// A two-entry response buffer (output register plus skid) keeps cmd.ready high
// while one response waits; cmd stalls only when both entries are full.
// rst is synchronous; all control and divider state returns to divide-by-four,
// prescale by 16, outputs high. cfg is always ready.
`default_nettype none
`include "assert_macros.svh"

module multi_output_clock_divider #(
  parameter int CHANNELS   = mocd_pkg::CHANNELS_DEF,
  parameter int MAX_DIVIDE = mocd_pkg::MAX_DIVIDE_DEF
) (
  input  wire         clk,
  input  wire         rst,
  mocd_cmd_if.sink    cmd,
  mocd_rsp_if.source  rsp,
  mocd_cfg_if.sink    cfg
);

  localparam int PAD_W = (CHANNELS > mocd_pkg::LEVEL_W) ? CHANNELS : mocd_pkg::LEVEL_W;
  localparam logic [mocd_pkg::CHAN_W-1:0] CHAN_LAST = mocd_pkg::CHAN_W'(CHANNELS - 1);
  localparam logic [mocd_pkg::DIV_W-1:0]  DIV_MAX   = mocd_pkg::DIV_W'(MAX_DIVIDE);

  // Configuration registers
  logic [mocd_pkg::SEL_W-1:0]   presc_sel;
  logic [mocd_pkg::CHAN_W-1:0]  top_chan;

  // Divider state
  logic [mocd_pkg::COUNT_W-1:0] high_m1      [CHANNELS];
  logic [mocd_pkg::COUNT_W-1:0] low_m1       [CHANNELS];
  logic [mocd_pkg::PHASE_W-1:0] phase        [CHANNELS];
  logic [CHANNELS-1:0]          bypass;
  logic [CHANNELS-1:0]          level;
  logic [mocd_pkg::PRESC_W-1:0] presc_count;

  logic [mocd_pkg::COUNT_W-1:0] high_m1_next [CHANNELS];
  logic [mocd_pkg::COUNT_W-1:0] low_m1_next  [CHANNELS];
  logic [mocd_pkg::PHASE_W-1:0] phase_next   [CHANNELS];
  logic [CHANNELS-1:0]          bypass_next;
  logic [CHANNELS-1:0]          level_next;
  logic [mocd_pkg::PRESC_W-1:0] presc_count_next;

  // Response buffer
  mocd_pkg::rsp_t main_rsp, skid_rsp, new_rsp;
  logic           main_valid, skid_valid;

  logic cmd_xfer, rsp_xfer;
  assign cmd_xfer = cmd.valid && cmd.ready;
  assign rsp_xfer = main_valid && rsp.ready;
  assign cmd.ready = !skid_valid;
  assign cfg.ready = 1'b1;

  // ---------------------------------------------------------------------
  // Command decode and next state
  // ---------------------------------------------------------------------
  logic [mocd_pkg::CHAN_W-1:0]  chan_top;
  logic                         chan_ok;
  logic [mocd_pkg::PHASE_W-1:0] presc_len;    // prescale factor P, 2..16
  logic [mocd_pkg::PHASE_W-1:0] presc_inc;
  logic                         presc_wrap;
  logic [mocd_pkg::PRESC_W-1:0] presc_tick;
  logic [mocd_pkg::DIV_W-1:0]   cfg_hi, cfg_lo;
  logic [mocd_pkg::DIV_W-1:0]   div_half;
  logic [mocd_pkg::COUNT_W-1:0] sel_hm1, sel_lm1;
  logic                         sel_bypass;
  logic [mocd_pkg::DIV_W-1:0]   rb_hi, rb_tot;
  logic [mocd_pkg::DIV_W-1:0]   ph_len, ph_inc;
  logic [mocd_pkg::DIV_W-1:0]   rb_div;
  logic [mocd_pkg::DUTY_W-1:0]  rb_mode;
  logic [mocd_pkg::STATUS_W-1:0] status;
  logic [PAD_W-1:0]             level_pad;

  always_comb begin
    chan_top   = (top_chan > CHAN_LAST) ? CHAN_LAST : top_chan;
    chan_ok    = cmd.channel <= chan_top;
    presc_len  = mocd_pkg::PHASE_W'(2) << presc_sel;
    presc_inc  = {1'b0, presc_count} + mocd_pkg::PHASE_W'(1);
    presc_wrap = presc_inc >= presc_len;
    presc_tick = presc_wrap ? '0 : presc_inc[mocd_pkg::PRESC_W-1:0];

    // Split of a configured divide into high and low phases
    div_half = cmd.divider >> 1;
    case (cmd.duty_sel)
      mocd_pkg::DUTY_MIN_HIGH: begin
        cfg_hi = mocd_pkg::min_part(cmd.divider);
        cfg_lo = cmd.divider - cfg_hi;
      end
      mocd_pkg::DUTY_MIN_LOW: begin
        cfg_lo = mocd_pkg::min_part(cmd.divider);
        cfg_hi = cmd.divider - cfg_lo;
      end
      default: begin
        cfg_hi = div_half;
        cfg_lo = cmd.divider - div_half;
      end
    endcase

    // Addressed channel for read back
    sel_hm1    = '0;
    sel_lm1    = '0;
    sel_bypass = 1'b0;
    for (int i = 0; i < CHANNELS; i++) begin
      if (cmd.channel == mocd_pkg::CHAN_W'(i)) begin
        sel_hm1    = high_m1[i];
        sel_lm1    = low_m1[i];
        sel_bypass = bypass[i];
      end
    end
    rb_hi  = mocd_pkg::DIV_W'(sel_hm1) + mocd_pkg::DIV_W'(1);
    rb_tot = rb_hi + mocd_pkg::DIV_W'(sel_lm1) + mocd_pkg::DIV_W'(1);

    high_m1_next     = high_m1;
    low_m1_next      = low_m1;
    phase_next       = phase;
    bypass_next      = bypass;
    level_next       = level;
    presc_count_next = presc_count;
    ph_len           = '0;
    ph_inc           = '0;
    rb_div           = '0;
    rb_mode          = mocd_pkg::DUTY_HALF;
    status           = mocd_pkg::ST_OK;

    case (cmd.action)
      mocd_pkg::ACT_TICK: begin
        presc_count_next = presc_tick;
        for (int i = 0; i < CHANNELS; i++) begin
          if (bypass[i]) begin
            level_next[i] = {1'b0, presc_tick} < (presc_len >> 1);
          end else if (presc_wrap) begin
            ph_len = level[i] ? mocd_pkg::DIV_W'(high_m1[i]) + mocd_pkg::DIV_W'(1)
                              : mocd_pkg::DIV_W'(low_m1[i]) + mocd_pkg::DIV_W'(1);
            ph_inc = mocd_pkg::DIV_W'(phase[i]) + mocd_pkg::DIV_W'(1);
            if (ph_inc >= ph_len) begin
              phase_next[i] = '0;
              level_next[i] = !level[i];
            end else begin
              phase_next[i] = ph_inc[mocd_pkg::PHASE_W-1:0];
            end
          end
        end
      end
      mocd_pkg::ACT_SYNC: begin
        presc_count_next = '0;
        level_next       = '1;
        for (int i = 0; i < CHANNELS; i++) begin
          phase_next[i] = '0;
        end
      end
      mocd_pkg::ACT_CONFIG: begin
        if (!chan_ok) begin
          status = mocd_pkg::ST_BAD_CHAN;
        end else if (cmd.divider == '0 || cmd.divider > DIV_MAX) begin
          status = mocd_pkg::ST_BAD_DIV;
        end else if (cmd.duty_sel == mocd_pkg::DUTY_BAD) begin
          status = mocd_pkg::ST_BAD_DUTY;
        end else begin
          for (int i = 0; i < CHANNELS; i++) begin
            if (cmd.channel == mocd_pkg::CHAN_W'(i)) begin
              if (cmd.divider == mocd_pkg::DIV_W'(1)) begin
                bypass_next[i] = 1'b1;
              end else begin
                bypass_next[i]  = 1'b0;
                high_m1_next[i] = mocd_pkg::COUNT_W'(cfg_hi - mocd_pkg::DIV_W'(1));
                low_m1_next[i]  = mocd_pkg::COUNT_W'(cfg_lo - mocd_pkg::DIV_W'(1));
              end
            end
          end
        end
      end
      default: begin  // read back
        if (!chan_ok) begin
          status = mocd_pkg::ST_BAD_CHAN;
        end else if (sel_bypass) begin
          rb_div = mocd_pkg::DIV_W'(1);
        end else begin
          rb_div = rb_tot;
          if (rb_hi == (rb_tot >> 1)) begin
            rb_mode = mocd_pkg::DUTY_HALF;
          end else if (rb_hi == mocd_pkg::min_part(rb_tot)) begin
            rb_mode = mocd_pkg::DUTY_MIN_HIGH;
          end else begin
            rb_mode = mocd_pkg::DUTY_MIN_LOW;
          end
        end
      end
    endcase

    level_pad                = PAD_W'(level_next);
    new_rsp.clock_levels     = level_pad[mocd_pkg::LEVEL_W-1:0];
    new_rsp.status           = status;
    new_rsp.readback_divider = rb_div;
    new_rsp.readback_duty    = rb_mode;
  end

  // ---------------------------------------------------------------------
  // State registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      presc_sel   <= mocd_pkg::PRESC_SEL_RST;
      top_chan    <= mocd_pkg::TOP_CHAN_RST;
      bypass      <= '0;
      level       <= '1;
      presc_count <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        high_m1[i] <= mocd_pkg::COUNT_RST;
        low_m1[i]  <= mocd_pkg::COUNT_RST;
        phase[i]   <= '0;
      end
    end else begin
      if (cfg.valid) begin
        case (cfg.index)
          mocd_pkg::REG_PRESC_SEL: presc_sel <= cfg.data[mocd_pkg::SEL_W-1:0];
          mocd_pkg::REG_TOP_CHAN:  top_chan  <= cfg.data[mocd_pkg::CHAN_W-1:0];
          default: ;
        endcase
      end
      if (cmd_xfer) begin
        high_m1     <= high_m1_next;
        low_m1      <= low_m1_next;
        phase       <= phase_next;
        bypass      <= bypass_next;
        level       <= level_next;
        presc_count <= presc_count_next;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Response buffer: main register drives rsp, skid catches one more
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (!main_valid || rsp_xfer) begin
        main_valid <= skid_valid || cmd_xfer;
        skid_valid <= 1'b0;
      end else if (cmd_xfer) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!main_valid || rsp_xfer) begin
      main_rsp <= skid_valid ? skid_rsp : new_rsp;
    end else if (cmd_xfer) begin
      skid_rsp <= new_rsp;
    end
  end

  assign rsp.valid            = main_valid;
  assign rsp.clock_levels     = main_rsp.clock_levels;
  assign rsp.status           = main_rsp.status;
  assign rsp.readback_divider = main_rsp.readback_divider;
  assign rsp.readback_duty    = main_rsp.readback_duty;

  // ---------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------
  `ASSERT_IMPLIES(a_skid_behind_main, clk, rst, skid_valid, main_valid)
  `ASSERT_IMPLIES(a_readback_only_ok, clk, rst,
                  main_valid && main_rsp.readback_divider != '0,
                  main_rsp.status == mocd_pkg::ST_OK)
  `ASSERT_NEXT(a_sync_clears_prescaler, clk, rst,
               cmd_xfer && cmd.action == mocd_pkg::ACT_SYNC,
               presc_count == '0 && level == '1)

endmodule

`default_nettype wire

// ----- verif/multi_output_clock_divider_test.sv -----
`default_nettype none

module multi_output_clock_divider_test;
  import mocd_pkg::*;

  // Cycles with no transfer on any channel before the run is declared hung.
  localparam int QUIET_LIMIT   = 3000;
  localparam int PHASES        = 6;
  localparam int ITEMS_PER_PHASE = 100;

  // One command as queued for the driver. hold makes the driver wait until
  // every earlier command has produced its response.
  typedef struct {
    action_t             action;
    logic [CHAN_W-1:0]   channel;
    logic [DIV_W-1:0]    divider;
    duty_t               duty_sel;
    bit                  hold;
  } cmd_item_t;

  logic clk = 1'b0;
  logic rst;

  mocd_cmd_if cmd_bus ();
  mocd_rsp_if rsp_bus ();
  mocd_cfg_if cfg_bus ();

  multi_output_clock_divider u_top (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_bus),
    .rsp (rsp_bus),
    .cfg (cfg_bus)
  );

  always #6 clk = ~clk;

  // Per phase: prescale select, highest channel, sender and receiver idle percent.
  // The third phase parks highest_channel above the last channel to check clamping.
  int sel_plan[PHASES]  = '{0, 1, 3, 2, 0, 3};
  int top_plan[PHASES]  = '{9, 4, 15, 7, 9, 5};
  int send_plan[PHASES] = '{29, 29, 61, 61, 0, 0};
  int recv_plan[PHASES] = '{61, 61, 29, 29, 0, 0};

  cmd_item_t pending_cmds[$];
  rsp_t      due_responses[$];

  int send_idle = 0;
  int recv_idle = 0;
  int n_sent    = 0;   // commands transferred
  int n_done    = 0;   // responses matched against a prediction
  int errors    = 0;
  int quiet     = 0;

  // ---------------------------------------------------------------------------
  // Predictor state: the divider bank as the block should hold it.
  // ---------------------------------------------------------------------------
  logic [SEL_W-1:0]   m_presc_sel;
  logic [CHAN_W-1:0]  m_top_chan;
  logic [COUNT_W-1:0] m_high_m1 [CHANNELS_DEF];
  logic [COUNT_W-1:0] m_low_m1  [CHANNELS_DEF];
  bit                 m_bypass  [CHANNELS_DEF];
  logic [PHASE_W-1:0] m_phase   [CHANNELS_DEF];
  bit                 m_level   [CHANNELS_DEF];
  logic [PRESC_W-1:0] m_presc;

  // Length of the short phase in the asymmetric duty modes.
  function automatic int short_phase(input int d);
    return (d < 18) ? 1 : d - 16;
  endfunction

  task automatic restart_counters();
    m_presc = '0;
    for (int i = 0; i < CHANNELS_DEF; i++) begin
      m_phase[i] = '0;
      m_level[i] = 1'b1;
    end
  endtask

  task automatic reset_divider_model();
    m_presc_sel = PRESC_SEL_RST;
    m_top_chan  = TOP_CHAN_RST;
    for (int i = 0; i < CHANNELS_DEF; i++) begin
      m_high_m1[i] = COUNT_RST;
      m_low_m1[i]  = COUNT_RST;
      m_bypass[i]  = 1'b0;
    end
    restart_counters();
  endtask

  // Applies one command to the predicted bank and returns the response it owes.
  task automatic predict_divider_response(input cmd_item_t c, output rsp_t r);
    int  p, top, d, hi, lo, tot, len;
    bit  wrap;
    r = '0;
    r.status = ST_OK;
    case (c.action)
      ACT_TICK: begin
        p = 2 << m_presc_sel;
        // A count left past the end by a prescale change wraps on this tick.
        wrap = (int'(m_presc) + 1 >= p);
        m_presc = wrap ? '0 : m_presc + 1'b1;
        for (int i = 0; i < CHANNELS_DEF; i++) begin
          if (m_bypass[i]) begin
            m_level[i] = (int'(m_presc) < p / 2);
          end else if (wrap) begin
            len = m_level[i] ? int'(m_high_m1[i]) + 1 : int'(m_low_m1[i]) + 1;
            if (int'(m_phase[i]) + 1 >= len) begin
              m_phase[i] = '0;
              m_level[i] = ~m_level[i];
            end else begin
              m_phase[i] = m_phase[i] + 1'b1;
            end
          end
        end
      end
      ACT_SYNC: begin
        restart_counters();
      end
      default: begin
        top = (int'(m_top_chan) > CHANNELS_DEF - 1) ? CHANNELS_DEF - 1 : int'(m_top_chan);
        d   = int'(c.divider);
        // Check order: channel, then divider, then duty mode.
        if (int'(c.channel) > top) begin
          r.status = ST_BAD_CHAN;
        end else if (c.action == ACT_CONFIG) begin
          if (d < 1 || d > MAX_DIVIDE_DEF) begin
            r.status = ST_BAD_DIV;
          end else if (c.duty_sel == DUTY_BAD) begin
            r.status = ST_BAD_DUTY;
          end else if (d == 1) begin
            // Bypass keeps the stored counts.
            m_bypass[c.channel] = 1'b1;
          end else begin
            case (c.duty_sel)
              DUTY_HALF: begin
                hi = d / 2;
                lo = d - hi;
              end
              DUTY_MIN_HIGH: begin
                hi = short_phase(d);
                lo = d - hi;
              end
              default: begin
                lo = short_phase(d);
                hi = d - lo;
              end
            endcase
            m_bypass[c.channel]  = 1'b0;
            m_high_m1[c.channel] = COUNT_W'(hi - 1);
            m_low_m1[c.channel]  = COUNT_W'(lo - 1);
          end
        end else if (m_bypass[c.channel]) begin
          r.readback_divider = DIV_W'(1);
          r.readback_duty    = DUTY_HALF;
        end else begin
          hi  = int'(m_high_m1[c.channel]) + 1;
          tot = hi + int'(m_low_m1[c.channel]) + 1;
          r.readback_divider = DIV_W'(tot);
          if (hi == tot / 2)
            r.readback_duty = DUTY_HALF;
          else if (hi == short_phase(tot))
            r.readback_duty = DUTY_MIN_HIGH;
          else
            r.readback_duty = DUTY_MIN_LOW;
        end
      end
    endcase
    for (int i = 0; i < CHANNELS_DEF; i++)
      r.clock_levels[i] = m_level[i];
  endtask

  // ---------------------------------------------------------------------------
  // Command driver: presents queued commands, idling at random.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    cmd_item_t nxt;
    bit        drained;
    if (rst) begin
      cmd_bus.valid <= 1'b0;
    end else if (!cmd_bus.valid || cmd_bus.ready) begin
      // Nothing in flight on the command side and every response back.
      drained = !cmd_bus.valid && (n_sent == n_done);
      if (pending_cmds.size() != 0 && (!pending_cmds[0].hold || drained) &&
          $urandom_range(99) >= send_idle) begin
        nxt = pending_cmds.pop_front();
        cmd_bus.valid    <= 1'b1;
        cmd_bus.action   <= nxt.action;
        cmd_bus.channel  <= nxt.channel;
        cmd_bus.divider  <= nxt.divider;
        cmd_bus.duty_sel <= nxt.duty_sel;
      end else begin
        cmd_bus.valid <= 1'b0;
      end
    end
  end

  // Response backpressure.
  always @(posedge clk) begin
    if (rst)
      rsp_bus.ready <= 1'b0;
    else
      rsp_bus.ready <= ($urandom_range(99) >= recv_idle);
  end

  // ---------------------------------------------------------------------------
  // Monitor: predicts on each command transfer, checks each response transfer.
  // Predict first so a same-edge response still finds its entry.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    cmd_item_t seen;
    rsp_t      want;
    if (!rst) begin
      if (cmd_bus.valid && cmd_bus.ready) begin
        seen.action   = action_t'(cmd_bus.action);
        seen.channel  = cmd_bus.channel;
        seen.divider  = cmd_bus.divider;
        seen.duty_sel = duty_t'(cmd_bus.duty_sel);
        seen.hold     = 1'b0;
        predict_divider_response(seen, want);
        due_responses.push_back(want);
        n_sent <= n_sent + 1;
      end
      if (rsp_bus.valid && rsp_bus.ready) begin
        if (due_responses.size() == 0) begin
          $error("response transfer with no command outstanding");
          errors++;
        end else begin
          want = due_responses.pop_front();
          n_done <= n_done + 1;
          if (rsp_bus.clock_levels !== want.clock_levels) begin
            $error("clock_levels: expected %h, got %h",
                   want.clock_levels, rsp_bus.clock_levels);
            errors++;
          end
          if (rsp_bus.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp_bus.status);
            errors++;
          end
          if (rsp_bus.readback_divider !== want.readback_divider) begin
            $error("readback_divider: expected %0d, got %0d",
                   want.readback_divider, rsp_bus.readback_divider);
            errors++;
          end
          if (rsp_bus.readback_duty !== want.readback_duty) begin
            $error("readback_duty: expected %0d, got %0d",
                   want.readback_duty, rsp_bus.readback_duty);
            errors++;
          end
        end
      end
    end
  end

  // Watchdog: any transfer resets the quiet count.
  always @(posedge clk) begin
    if (rst || (cmd_bus.valid && cmd_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("multi_output_clock_divider_test: FAIL");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  function automatic cmd_item_t make_cmd(input action_t a, input int ch, input int d,
                                         input int m);
    cmd_item_t c;
    c.action   = a;
    c.channel  = CHAN_W'(ch);
    c.divider  = DIV_W'(d);
    c.duty_sel = duty_t'(m);
    c.hold     = 1'b0;
    return c;
  endfunction

  // Mostly in-range channels; occasionally any of the 16 codes.
  function automatic int pick_channel();
    return ($urandom_range(9) != 0) ? $urandom_range(0, 9) : $urandom_range(0, 15);
  endfunction

  // Mix weighted toward ticks and legal configures so outputs actually toggle.
  function automatic cmd_item_t random_cmd();
    cmd_item_t c;
    int        r, d;
    r = $urandom_range(99);
    c = make_cmd(ACT_TICK, $urandom_range(0, 15), $urandom_range(0, 63),
                 $urandom_range(0, 3));
    if (r < 55) begin
      c.action = ACT_TICK;
    end else if (r < 75) begin
      if ($urandom_range(6) == 0)
        d = $urandom_range(0, 63);
      else if ($urandom_range(1) == 0)
        d = $urandom_range(1, 6);
      else
        d = $urandom_range(1, 32);
      c = make_cmd(ACT_CONFIG, pick_channel(), d,
                   ($urandom_range(9) != 0) ? $urandom_range(0, 2) : 3);
    end else if (r < 90) begin
      c.action  = ACT_READ;
      c.channel = CHAN_W'(pick_channel());
    end else if (r < 94) begin
      c.action = ACT_SYNC;
    end else begin
      c.action = action_t'($urandom_range(0, 3));   // fully random noise
    end
    return c;
  endfunction

  // Extremes, every action, every status and the check-order cases.
  task automatic queue_directed();
    pending_cmds.push_back(make_cmd(ACT_TICK, 0, 0, 0));
    pending_cmds.push_back(make_cmd(ACT_TICK, 15, 63, 3));
    pending_cmds.push_back(make_cmd(ACT_CONFIG, 0, 1, 0));     // bypass
    pending_cmds.push_back(make_cmd(ACT_TICK, 0, 0, 0));
    pending_cmds.push_back(make_cmd(ACT_TICK, 0, 0, 0));
    pending_cmds.push_back(make_cmd(ACT_READ, 0, 0, 0));
    pending_cmds.push_back(make_cmd(ACT_CONFIG, 1, 32, 0));
    pending_cmds.push_back(make_cmd(ACT_READ, 1, 0, 0));
    pending_cmds.push_back(make_cmd(ACT_CONFIG, 2, 32, 1));    // reads back as half
    pending_cmds.push_back(make_cmd(ACT_READ, 2, 0, 0));
    pending_cmds.push_back(make_cmd(ACT_CONFIG, 3, 18, 2));    // long low rule
    pending_cmds.push_back(make_cmd(ACT_READ, 3, 0, 0));
    pending_cmds.push_back(make_cmd(ACT_CONFIG, 4, 2, 1));
    pending_cmds.push_back(make_cmd(ACT_CONFIG, 0, 0, 0));     // divider too small
    pending_cmds.push_back(make_cmd(ACT_CONFIG, 0, 63, 0));    // divider too large
    pending_cmds.push_back(make_cmd(ACT_CONFIG, 0, 33, 3));    // divider beats duty
    pending_cmds.push_back(make_cmd(ACT_CONFIG, 5, 4, 3));     // bad duty
    pending_cmds.push_back(make_cmd(ACT_CONFIG, 15, 0, 3));    // channel beats all
    pending_cmds.push_back(make_cmd(ACT_READ, 10, 0, 0));      // first missing channel
    pending_cmds.push_back(make_cmd(ACT_CONFIG, 9, 3, 2));
    pending_cmds.push_back(make_cmd(ACT_READ, 9, 0, 0));
    pending_cmds.push_back(make_cmd(ACT_TICK, 0, 0, 0));
    pending_cmds.push_back(make_cmd(ACT_SYNC, 7, 21, 1));
    pending_cmds.push_back(make_cmd(ACT_READ, 0, 63, 3));      // unused fields set
    pending_cmds.push_back(make_cmd(ACT_TICK, 0, 0, 0));
  endtask

  task automatic write_reg(input cfg_reg_t idx, input int val);
    @(posedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= CFG_DAT_W'(val);
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    case (idx)
      REG_PRESC_SEL: m_presc_sel = SEL_W'(val);
      REG_TOP_CHAN:  m_top_chan  = CHAN_W'(val);
      default: ;
    endcase
  endtask

  // Sampled on the falling edge, away from the driver and monitor updates.
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_cmds.size() != 0 || cmd_bus.valid || n_sent != n_done);
  endtask

  initial begin
    int hold_at;
    rst               = 1'b1;
    cmd_bus.valid     = 1'b0;
    cmd_bus.action    = ACT_TICK;
    cmd_bus.channel   = '0;
    cmd_bus.divider   = '0;
    cmd_bus.duty_sel  = DUTY_HALF;
    rsp_bus.ready     = 1'b0;
    cfg_bus.valid     = 1'b0;
    cfg_bus.index     = REG_PRESC_SEL;
    cfg_bus.data      = '0;
    reset_divider_model();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    for (int ph = 0; ph < PHASES; ph++) begin
      // Block is idle here: nothing queued, nothing in flight.
      write_reg(REG_PRESC_SEL, sel_plan[ph]);
      write_reg(REG_TOP_CHAN, top_plan[ph]);
      @(negedge clk);
      send_idle = send_plan[ph];
      recv_idle = recv_plan[ph];
      if (ph == 0)
        queue_directed();
      hold_at = $urandom_range(10, ITEMS_PER_PHASE - 10);
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        pending_cmds.push_back(random_cmd());
        if (k == hold_at)
          pending_cmds[pending_cmds.size() - 1].hold = 1'b1;
      end
      wait_drained();
    end

    // Let a stray late response show up before the verdict.
    repeat (8) @(negedge clk);
    if (due_responses.size() != 0) begin
      $error("%0d responses never arrived", due_responses.size());
      errors++;
    end
    if (errors == 0)
      $display("multi_output_clock_divider_test: PASS");
    else
      $display("multi_output_clock_divider_test: FAIL");
    $finish;
  end

endmodule

`default_nettype wire

// ----- sim.f -----
+incdir+sv
sv/mocd_pkg.sv
sv/mocd_ifs.sv
sv/multi_output_clock_divider.sv
verif/multi_output_clock_divider_test.sv
